### hw/rtl/lclt_pkg.sv
`default_nettype none

package lclt_pkg;

    localparam int OP_W    = 2;
    localparam int SLOPE_W = 32;
    localparam int ICPT_W  = 41;
    localparam int POINT_W = 10;
    localparam int MIN_W   = 61;

    localparam logic signed [MIN_W-1:0] EMPTY_VALUE = 61'sd1000000000000000005;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic signed [SLOPE_W-1:0]  slope;
        logic signed [ICPT_W-1:0]   icpt;
        logic        [POINT_W-1:0]  point;
    } item_t;

    // head of the command queue as seen by the walker
    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

    typedef struct packed {
        logic                       occ;
        logic signed [SLOPE_W-1:0]  slope;
        logic signed [ICPT_W-1:0]   icpt;
    } node_t;

endpackage

`default_nettype wire

### hw/rtl/lclt_ifs.sv
`default_nettype none

interface lclt_req_if import lclt_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            operation;
    logic signed [SLOPE_W-1:0]  line_slope;
    logic signed [ICPT_W-1:0]   line_intercept;
    logic [POINT_W-1:0]         query_point;

    modport source (output valid, operation, line_slope, line_intercept, query_point,
                    input ready);
    modport sink   (input valid, operation, line_slope, line_intercept, query_point,
                    output ready);
endinterface

interface lclt_rsp_if import lclt_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [MIN_W-1:0]  min_value;
    logic                     no_line;

    modport source (output valid, min_value, no_line, input ready);
    modport sink   (input valid, min_value, no_line, output ready);
endinterface

`default_nettype wire

### hw/rtl/lclt_front.sv
`default_nettype none

module lclt_front import lclt_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    lclt_req_if.sink    req,
    output q_head_t     q_head,
    input  wire logic   pop
);

    item_t       q_mem [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        accept;
    logic        push;
    op_t         op_in;

    assign op_in     = op_t'(req.operation);
    assign req.ready = (count_reg != 2'd2);
    assign accept    = req.valid && req.ready;
    // drop unused codes at the door
    assign push      = accept && (op_in inside {OP_INSERT, OP_QUERY, OP_CLEAR});

    assign q_head.valid = (count_reg != 2'd0);
    assign q_head.item  = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= '{op: op_in, slope: req.line_slope,
                                   icpt: req.line_intercept, point: req.query_point};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lclt_back.sv
`default_nettype none

module lclt_back import lclt_pkg::*;
#(
    parameter int POINT_COUNT = 1024
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  q_head_t     q_head,
    output logic        pop,
    lclt_rsp_if.source  rsp
);

    localparam int PW         = (POINT_COUNT > 1) ? $clog2(POINT_COUNT) : 1;
    localparam int IW         = PW + 1;
    localparam int NODE_COUNT = 2 * POINT_COUNT;
    localparam int CW         = (PW > POINT_W) ? PW : POINT_W;
    localparam int PRW        = SLOPE_W + CW + 1;
    localparam int VW         = PRW + 1;
    localparam logic [PW-1:0] LAST_POINT = PW'(POINT_COUNT - 1);
    localparam logic [IW-1:0] LAST_NODE  = IW'(NODE_COUNT - 1);

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_DEC,
        ST_DELIVER
    } state_t;

    state_t                     state_reg;
    logic [IW-1:0]              sweep_reg;
    logic [PW-1:0]              l_reg;
    logic [PW-1:0]              r_reg;
    logic                       is_query_reg;
    logic signed [SLOPE_W-1:0]  m_reg;
    logic signed [ICPT_W-1:0]   c_reg;
    logic [POINT_W-1:0]         x_reg;
    node_t                      rd_reg;
    logic signed [PRW-1:0]      pn0_reg;
    logic signed [PRW-1:0]      ps0_reg;
    logic signed [PRW-1:0]      pn1_reg;
    logic signed [PRW-1:0]      ps1_reg;
    logic signed [VW-1:0]       best_reg;
    logic                       hit_reg;
    logic                       out_valid_reg;
    logic signed [MIN_W-1:0]    out_min_reg;
    logic                       out_none_reg;

    node_t                      mem [NODE_COUNT];

    logic [IW-1:0]              sum;
    logic                       leaf;
    logic [IW-1:0]              id;
    logic [PW-1:0]              mid;
    logic [IW-1:0]              mid1;
    logic [CW:0]                pt0;
    logic [CW:0]                pt1;
    logic signed [VW-1:0]       vn0;
    logic signed [VW-1:0]       vs0;
    logic signed [VW-1:0]       vn1;
    logic signed [VW-1:0]       vs1;
    logic                       lef;
    logic                       mide;
    logic                       go_left;
    logic                       mem_we;
    logic [IW-1:0]              waddr;
    node_t                      wdata;

    assign sum     = {1'b0, l_reg} + {1'b0, r_reg};
    assign leaf    = (l_reg == r_reg);
    assign id      = sum | {{PW{1'b0}}, !leaf};
    assign mid     = sum[PW:1];
    assign mid1    = {1'b0, mid} + {{PW{1'b0}}, 1'b1};
    assign pt0     = is_query_reg ? (CW+1)'(x_reg) : (CW+1)'(l_reg);
    assign pt1     = (CW+1)'(mid1);

    assign vn0     = VW'(pn0_reg) + VW'(c_reg);
    assign vs0     = VW'(ps0_reg) + VW'($signed(rd_reg.icpt));
    assign vn1     = VW'(pn1_reg) + VW'(c_reg);
    assign vs1     = VW'(ps1_reg) + VW'($signed(rd_reg.icpt));
    assign lef     = (vn0 < vs0);
    assign mide    = (vn1 < vs1);
    assign go_left = is_query_reg ? (CW'(x_reg) <= CW'(mid)) : (lef != mide);

    assign pop = (state_reg == ST_IDLE) && q_head.valid;

    always_comb
    begin
        mem_we = 1'b0;
        waddr  = id;
        wdata  = '{occ: 1'b1, slope: m_reg, icpt: c_reg};
        if (state_reg == ST_SWEEP)
        begin
            mem_we = 1'b1;
            waddr  = sweep_reg;
            wdata  = '0;
        end
        else if (state_reg == ST_DEC && !is_query_reg)
        begin
            mem_we = !rd_reg.occ || (leaf ? lef : mide);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        if (state_reg == ST_READ)
        begin
            rd_reg <= mem[id];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            pn0_reg <= m_reg * $signed(pt0);
            ps0_reg <= $signed(rd_reg.slope) * $signed(pt0);
            pn1_reg <= m_reg * $signed(pt1);
            ps1_reg <= $signed(rd_reg.slope) * $signed(pt1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            sweep_reg     <= '0;
            l_reg         <= '0;
            r_reg         <= LAST_POINT;
            is_query_reg  <= 1'b0;
            m_reg         <= '0;
            c_reg         <= '0;
            x_reg         <= '0;
            best_reg      <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_min_reg   <= '0;
            out_none_reg  <= 1'b0;
        end
        else
        begin
            if (rsp.ready && state_reg != ST_DELIVER)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_SWEEP:
                begin
                    if (sweep_reg == LAST_NODE)
                    begin
                        sweep_reg <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        sweep_reg <= sweep_reg + {{(IW-1){1'b0}}, 1'b1};
                    end
                end
                ST_IDLE:
                begin
                    if (q_head.valid)
                    begin
                        m_reg        <= q_head.item.slope;
                        c_reg        <= q_head.item.icpt;
                        x_reg        <= q_head.item.point;
                        is_query_reg <= (q_head.item.op == OP_QUERY);
                        l_reg        <= '0;
                        r_reg        <= LAST_POINT;
                        hit_reg      <= 1'b0;
                        best_reg     <= '0;
                        state_reg    <= (q_head.item.op == OP_CLEAR) ? ST_SWEEP : ST_READ;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    state_reg <= ST_DEC;
                end
                ST_DEC:
                begin
                    if (is_query_reg)
                    begin
                        if (rd_reg.occ)
                        begin
                            hit_reg <= 1'b1;
                            if (!hit_reg || vs0 < best_reg)
                            begin
                                best_reg <= vs0;
                            end
                        end
                    end
                    else if (!is_query_reg && mide && rd_reg.occ && !leaf)
                    begin
                        // winner stays, loser walks on
                        m_reg <= rd_reg.slope;
                        c_reg <= rd_reg.icpt;
                    end
                    if (leaf)
                    begin
                        state_reg <= is_query_reg ? ST_DELIVER : ST_IDLE;
                    end
                    else if (!is_query_reg && !rd_reg.occ)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        if (go_left)
                        begin
                            r_reg <= mid;
                        end
                        else
                        begin
                            l_reg <= mid1[PW-1:0];
                        end
                        state_reg <= ST_READ;
                    end
                end
                ST_DELIVER:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_min_reg   <= hit_reg ? MIN_W'(best_reg) : EMPTY_VALUE;
                        out_none_reg  <= !hit_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.min_value = out_min_reg;
    assign rsp.no_line   = out_none_reg;

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_SWEEP || state_reg == ST_DEC))
        else $error("node store written outside sweep or decide");

    a_clear_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
        pop && q_head.item.op == OP_CLEAR |=> state_reg == ST_SWEEP)
        else $error("clear did not start a sweep");

    a_query_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DEC && is_query_reg && leaf |=> state_reg == ST_DELIVER)
        else $error("query walk did not end at a leaf");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == ST_IDLE)
        else $error("queue popped while busy");

endmodule

`default_nettype wire

### hw/rtl/lichao_min_line_tree.sv
// Li Chao minimum-line tree over points 0..POINT_COUNT-1. Requests arrive on req
// (insert a line, query the minimum at a point, clear all lines) and go through a
// two-entry queue to a walker that reads one node of the single-port node store per
// level. Each level passes through three steps (store read, multiply, compare and update).
// A clear, and reset, sweep the node store one entry a cycle, during which queued
// requests wait. Only queries return a transfer on rsp; min_value is 1e18+5 with
// no_line set when no line lies on the query path.
`default_nettype none

module lichao_min_line_tree import lclt_pkg::*;
#(
    parameter int POINT_COUNT = 1024
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    lclt_req_if.sink    req,
    lclt_rsp_if.source  rsp
);

    q_head_t q_head;
    logic    pop;

    lclt_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .q_head (q_head),
        .pop    (pop)
    );

    lclt_back #(
        .POINT_COUNT (POINT_COUNT)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_head (q_head),
        .pop    (pop),
        .rsp    (rsp)
    );

endmodule

`default_nettype wire
